// ----- hw/rtl/pdrx_pkg.sv -----
// Package for the USB PD 4b5b packet receiver.
// Holds line codes, result event codes, the ordered-set patterns and the
// 4b5b decode and nibble CRC-32 functions. No dependencies.
`timescale 1ns / 1ps

package pdrx_pkg;

    typedef logic [4:0] sym_t;

    localparam sym_t K_SYNC1 = 5'h18;
    localparam sym_t K_SYNC2 = 5'h11;
    localparam sym_t K_SYNC3 = 5'h06;
    localparam sym_t K_RST1  = 5'h07;
    localparam sym_t K_RST2  = 5'h19;
    localparam sym_t K_EOP   = 5'h0d;

    localparam logic [2:0] EV_OS_SYM   = 3'd0;
    localparam logic [2:0] EV_OS_DONE  = 3'd1;
    localparam logic [2:0] EV_LOW_NIB  = 3'd2;
    localparam logic [2:0] EV_BYTE     = 3'd3;
    localparam logic [2:0] EV_EOP      = 3'd4;

    localparam logic [2:0] SOP_NONE    = 3'd7;

    localparam logic [31:0] CRC_INIT   = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY   = 32'hedb8_8320;
    // Good residue in register bit order (bit reverse of 0xc704dd7b).
    localparam logic [31:0] CRC_GOOD   = 32'hdebb_20e3;

    localparam int NUM_PATTERNS = 7;

    localparam sym_t OS_PATTERN [NUM_PATTERNS][4] = '{
        '{K_SYNC1, K_SYNC1, K_SYNC1, K_SYNC2},
        '{K_SYNC1, K_SYNC1, K_SYNC3, K_SYNC3},
        '{K_SYNC1, K_SYNC3, K_SYNC1, K_SYNC3},
        '{K_SYNC1, K_RST2,  K_RST2,  K_SYNC3},
        '{K_SYNC1, K_RST2,  K_SYNC3, K_SYNC2},
        '{K_RST1,  K_RST1,  K_RST1,  K_RST2},
        '{K_RST1,  K_SYNC1, K_RST1,  K_SYNC3}
    };

    // Bit 4 set marks a valid data code, the low four bits hold its value.
    localparam logic [4:0] DEC5B [32] = '{
        5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00,
        5'h00, 5'h11, 5'h14, 5'h15, 5'h00, 5'h00, 5'h16, 5'h17,
        5'h00, 5'h00, 5'h18, 5'h19, 5'h12, 5'h13, 5'h1a, 5'h1b,
        5'h00, 5'h00, 5'h1c, 5'h1d, 5'h1e, 5'h1f, 5'h10, 5'h00
    };

    // Returns the first pattern that matches in at least three positions.
    function automatic logic [2:0] classify(input sym_t s0, input sym_t s1,
                                            input sym_t s2, input sym_t s3);
        logic [2:0] result;
        logic [2:0] hits;
        result = SOP_NONE;
        for (int p = NUM_PATTERNS - 1; p >= 0; p--)
        begin
            hits = 3'((s0 == OS_PATTERN[p][0])) + 3'((s1 == OS_PATTERN[p][1]))
                 + 3'((s2 == OS_PATTERN[p][2])) + 3'((s3 == OS_PATTERN[p][3]));
            if (hits >= 3'd3)
            begin
                result = 3'(p);
            end
        end
        return result;
    endfunction

    function automatic logic [31:0] crc_nibble(input logic [31:0] crc,
                                               input logic [3:0] nib);
        logic [31:0] c;
        c = crc ^ {28'd0, nib};
        for (int i = 0; i < 4; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [3:0] next_offset(input logic [3:0] off);
        logic [2:0] n;
        n = 3'(off + 4'd5);
        return (n == 3'd0) ? 4'd8 : {1'b0, n};
    endfunction

endpackage

// ----- hw/rtl/pd_4b5b_packet_receiver.sv -----
// USB PD 4b5b packet receiver: sync hunt, ordered-set classification,
// 4b5b decode and nibble CRC-32 check. Depends on pdrx_pkg.
//
//   Channel  Signals                     Direction  Payload
//   in       in_valid / in_ready         input      line_byte
//   out      out_valid / out_ready       output     event_res .. last
//
// A line byte yields zero, one or two symbols and one result per symbol.
// A byte that yields two symbols passes them one at a time through the
// single symbol decode and CRC path, and keeps the input register meanwhile.
// The input register takes a new byte in the cycle its last symbol moves
// to the result register, so bytes flow back to back while out_ready holds.
// A stalled result register holds the symbol path; a byte with no symbol
// found while hunting is consumed even during a stall.
// Reset returns to hunting with the CRC at all ones; there is no clearing pass.
`timescale 1ns / 1ps

module pd_4b5b_packet_receiver #(
    parameter int MAX_PACKET_BYTES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           line_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           event_res,
    output logic [2:0]           sop_type,
    output logic [4:0]           raw_symbol,
    output logic [3:0]           nibble,
    output logic [7:0]           data_byte,
    output logic [5:0]           byte_index,
    output logic                 code_error,
    output logic [31:0]          crc_value,
    output logic                 crc_ok,
    output logic                 last
);
    import pdrx_pkg::*;

    localparam int BW = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [2:0] SC_HUNT = 3'd0;
    localparam logic [2:0] SC_OS_LAST = 3'd3;
    localparam logic [2:0] SC_LOW = 3'd4;
    localparam logic [2:0] SC_HIGH = 3'd5;

    logic            in_full_reg;
    logic [7:0]      in_byte_reg;
    logic            phase_reg;
    logic [7:0]      prev_byte_reg;
    logic [3:0]      bit_offset_reg;
    logic [2:0]      sym_count_reg;
    sym_t            os_store_reg [4];
    logic [31:0]     crc_reg;
    logic [3:0]      pend_nib_reg;
    logic [2:0]      sop_reg;
    logic [BW-1:0]   bytes_done_reg;

    logic            out_valid_reg;
    logic [2:0]      event_res_reg;
    logic [2:0]      sop_type_reg;
    sym_t            raw_symbol_reg;
    logic [3:0]      nibble_reg;
    logic [7:0]      data_byte_reg;
    logic [5:0]      byte_index_reg;
    logic            code_error_reg;
    logic [31:0]     crc_value_reg;
    logic            crc_ok_reg;
    logic            last_reg;

    logic [15:0]     win;
    logic            hunting;
    logic            hit;
    logic [3:0]      hit_off;
    logic            skip;
    logic            out_free;
    logic            step;
    logic            done_item;
    logic [3:0]      off_cur;
    logic [3:0]      shift_amt;
    sym_t            sym;
    logic [2:0]      sop_cur;
    logic [BW-1:0]   bytes_cur;
    logic [BW-1:0]   bytes_inc;
    logic [3:0]      off_next;
    logic            second;

    logic [4:0]      code;
    logic [3:0]      dec_nib;
    logic [31:0]     crc_data;

    logic            ended;
    logic [2:0]      sym_count_next;
    logic [31:0]     crc_next;
    logic [3:0]      pend_nib_next;
    logic [2:0]      sop_next;
    logic [BW-1:0]   bytes_done_next;
    logic [2:0]      ev_next;
    logic [3:0]      nib_next;
    logic [7:0]      byte_next;
    logic [5:0]      idx_next;
    logic            err_next;
    logic            ok_next;

    assign win = {in_byte_reg, prev_byte_reg};
    assign hunting = (sym_count_reg == SC_HUNT) && !phase_reg;

    always_comb
    begin
        hit = 1'b0;
        hit_off = 4'd8;
        for (int s = 1; s <= 8; s++)
        begin
            if ((5'(win >> s) == K_SYNC1) || (5'(win >> s) == K_RST1))
            begin
                hit = 1'b1;
                hit_off = 4'(s);
            end
        end
    end

    assign skip = in_full_reg && hunting && !hit;
    assign out_free = !out_valid_reg || out_ready;
    assign step = in_full_reg && !skip && out_free;

    assign off_cur = hunting ? hit_off : bit_offset_reg;
    assign shift_amt = phase_reg ? off_cur + 4'd8 : off_cur;
    assign sym = 5'(win >> shift_amt);
    assign sop_cur = hunting ? SOP_NONE : sop_reg;
    assign bytes_cur = hunting ? '0 : bytes_done_reg;
    assign bytes_inc = bytes_cur + BW'(1);
    assign off_next = next_offset(off_cur);

    assign code = DEC5B[sym];
    assign dec_nib = code[3:0];
    assign crc_data = crc_nibble(crc_reg, dec_nib);

    always_comb
    begin
        ended = 1'b0;
        sym_count_next = sym_count_reg;
        crc_next = crc_reg;
        pend_nib_next = pend_nib_reg;
        sop_next = sop_cur;
        bytes_done_next = bytes_cur;
        ev_next = EV_OS_SYM;
        nib_next = 4'd0;
        byte_next = 8'd0;
        idx_next = 6'd0;
        err_next = 1'b0;
        ok_next = 1'b0;
        if (sym == K_EOP)
        begin
            ended = 1'b1;
            sym_count_next = SC_HUNT;
            ev_next = EV_EOP;
            ok_next = (crc_reg == CRC_GOOD);
        end
        else if (sym_count_reg < SC_LOW)
        begin
            sym_count_next = sym_count_reg + 3'd1;
            if (sym_count_reg == SC_OS_LAST)
            begin
                sop_next = classify(os_store_reg[0], os_store_reg[1],
                                    os_store_reg[2], sym);
                crc_next = CRC_INIT;
                pend_nib_next = 4'd0;
                ev_next = EV_OS_DONE;
            end
        end
        else
        begin
            crc_next = crc_data;
            nib_next = dec_nib;
            err_next = !code[4];
            idx_next = (bytes_cur > BW'(63)) ? 6'd63 : bytes_cur[5:0];
            if (sym_count_reg == SC_LOW)
            begin
                pend_nib_next = dec_nib;
                sym_count_next = SC_HIGH;
                ev_next = EV_LOW_NIB;
            end
            else
            begin
                byte_next = {dec_nib, pend_nib_reg};
                sym_count_next = SC_LOW;
                ev_next = EV_BYTE;
                bytes_done_next = bytes_inc;
                if (bytes_inc >= BW'(MAX_PACKET_BYTES))
                begin
                    sym_count_next = SC_HUNT;
                    ended = 1'b1;
                end
            end
        end
    end

    assign second = !phase_reg && !ended && (off_next < 4'd4);
    assign done_item = skip || (step && !second);
    assign in_ready = !in_full_reg || done_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            phase_reg <= 1'b0;
            prev_byte_reg <= 8'd0;
            bit_offset_reg <= 4'd8;
            sym_count_reg <= SC_HUNT;
            crc_reg <= CRC_INIT;
            pend_nib_reg <= 4'd0;
            sop_reg <= SOP_NONE;
            bytes_done_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_full_reg <= 1'b1;
            end
            else if (done_item)
            begin
                in_full_reg <= 1'b0;
            end
            if (done_item)
            begin
                prev_byte_reg <= in_byte_reg;
            end
            if (step)
            begin
                phase_reg <= second;
                bit_offset_reg <= off_next;
                sym_count_reg <= sym_count_next;
                crc_reg <= crc_next;
                pend_nib_reg <= pend_nib_next;
                sop_reg <= sop_next;
                bytes_done_reg <= bytes_done_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= line_byte;
        end
        if (step && (sym != K_EOP) && (sym_count_reg < SC_LOW))
        begin
            os_store_reg[sym_count_reg[1:0]] <= sym;
        end
        if (step)
        begin
            event_res_reg <= ev_next;
            sop_type_reg <= sop_next;
            raw_symbol_reg <= sym;
            nibble_reg <= nib_next;
            data_byte_reg <= byte_next;
            byte_index_reg <= idx_next;
            code_error_reg <= err_next;
            crc_value_reg <= crc_next;
            crc_ok_reg <= ok_next;
            last_reg <= !second;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_res_reg;
    assign sop_type = sop_type_reg;
    assign raw_symbol = raw_symbol_reg;
    assign nibble = nibble_reg;
    assign data_byte = data_byte_reg;
    assign byte_index = byte_index_reg;
    assign code_error = code_error_reg;
    assign crc_value = crc_value_reg;
    assign crc_ok = crc_ok_reg;
    assign last = last_reg;

endmodule

// ----- hw/rtl/pdrx_checker.sv -----
// Port-level checks for the USB PD 4b5b packet receiver.
// Depends on pdrx_pkg; bound to pd_4b5b_packet_receiver at the end of the file.
`timescale 1ns / 1ps

module pdrx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  line_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  event_res,
    input logic [2:0]  sop_type,
    input logic [4:0]  raw_symbol,
    input logic [3:0]  nibble,
    input logic [7:0]  data_byte,
    input logic [5:0]  byte_index,
    input logic        code_error,
    input logic [31:0] crc_value,
    input logic        crc_ok,
    input logic        last
);
    import pdrx_pkg::*;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(line_byte))
        else $error("Waiting input item changed.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(raw_symbol) && $stable(crc_value) && $stable(last))
        else $error("Stalled result item changed.");

    a_eop_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_EOP) |->
            last && (raw_symbol == K_EOP) && (crc_ok == (crc_value == CRC_GOOD)))
        else $error("End of packet item is inconsistent.");

    a_ok_only_eop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != EV_EOP) |-> !crc_ok)
        else $error("CRC good flag outside end of packet.");

    a_os_sym_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_OS_SYM) |->
            (sop_type == SOP_NONE) && (nibble == 4'd0) && (data_byte == 8'd0)
            && !code_error && (byte_index == 6'd0))
        else $error("Ordered-set symbol item carries data fields.");

endmodule

bind pd_4b5b_packet_receiver pdrx_checker u_pdrx_checker (.*);

// ----- tb/sv/tb_pd_4b5b_packet_receiver.sv -----
`timescale 1ns / 1ps
// Testbench for pd_4b5b_packet_receiver: feeds line bit streams of framed packets and
// noise, predicts every result item and checks it field by field.
// Depends on pdrx_pkg and pd_4b5b_packet_receiver.

module tb_pd_4b5b_packet_receiver;
    import pdrx_pkg::*;

    localparam int MAX_BYTES = 64;

    typedef struct packed {
        logic [2:0]  ev;
        logic [2:0]  sop;
        logic [4:0]  sym;
        logic [3:0]  nib;
        logic [7:0]  dbyte;
        logic [5:0]  idx;
        logic        err;
        logic [31:0] crc;
        logic        ok;
        logic        last;
    } rx_result_t;

    class pd_rx_scoreboard;
        rx_result_t  pending_events[$];
        int          errors;
        logic [7:0]  prev_byte;
        int          bit_off;
        int          sym_cnt;
        logic [4:0]  os_syms[4];
        logic [31:0] crc_reg;
        logic [3:0]  low_nib;
        logic [2:0]  sop;
        int          bytes_done;

        function new();
            errors = 0;
            prev_byte = '0;
            bit_off = 8;
            sym_cnt = 0;
            crc_reg = CRC_INIT;
            low_nib = '0;
            sop = SOP_NONE;
            bytes_done = 0;
        endfunction

        static function logic [4:0] encode(logic [3:0] n);
            case (n)
                4'h0: return 5'h1e;
                4'h1: return 5'h09;
                4'h2: return 5'h14;
                4'h3: return 5'h15;
                4'h4: return 5'h0a;
                4'h5: return 5'h0b;
                4'h6: return 5'h0e;
                4'h7: return 5'h0f;
                4'h8: return 5'h12;
                4'h9: return 5'h13;
                4'ha: return 5'h16;
                4'hb: return 5'h17;
                4'hc: return 5'h1a;
                4'hd: return 5'h1b;
                4'he: return 5'h1c;
                default: return 5'h1d;
            endcase
        endfunction

        static function logic [4:0] pattern_sym(int p, int i);
            logic [4:0] pat [7][4];
            pat = '{
                '{K_SYNC1, K_SYNC1, K_SYNC1, K_SYNC2},
                '{K_SYNC1, K_SYNC1, K_SYNC3, K_SYNC3},
                '{K_SYNC1, K_SYNC3, K_SYNC1, K_SYNC3},
                '{K_SYNC1, K_RST2,  K_RST2,  K_SYNC3},
                '{K_SYNC1, K_RST2,  K_SYNC3, K_SYNC2},
                '{K_RST1,  K_RST1,  K_RST1,  K_RST2},
                '{K_RST1,  K_SYNC1, K_RST1,  K_SYNC3}
            };
            return pat[p][i];
        endfunction

        static function logic [31:0] crc_step(logic [31:0] c, logic [3:0] n);
            logic [31:0] r;
            r = c ^ {28'd0, n};
            for (int i = 0; i < 4; i++)
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function logic [2:0] classify();
            int hits;
            for (int p = 0; p < 7; p++)
            begin
                hits = 0;
                for (int i = 0; i < 4; i++)
                    if (os_syms[i] == pattern_sym(p, i))
                        hits++;
                if (hits >= 3)
                    return 3'(p);
            end
            return SOP_NONE;
        endfunction

        function int next_off(int o);
            int n;
            n = (o + 5) % 8;
            return (n == 0) ? 8 : n;
        endfunction

        // Handles one aligned symbol; returns 1 when the packet has ended.
        function bit take_symbol(logic [4:0] sym);
            rx_result_t  r;
            logic [31:0] rev;
            logic [3:0]  nib;
            bit          valid;
            r = '0;
            r.sym = sym;
            if (sym == K_EOP)
            begin
                rev = {<<{crc_reg}};
                r.ev = EV_EOP;
                r.sop = sop;
                r.crc = crc_reg;
                r.ok = (rev == 32'hc704dd7b);
                sym_cnt = 0;
                pending_events.push_back(r);
                return 1;
            end
            if (sym_cnt < 4)
            begin
                os_syms[sym_cnt] = sym;
                sym_cnt++;
                r.ev = EV_OS_SYM;
                if (sym_cnt == 4)
                begin
                    sop = classify();
                    crc_reg = CRC_INIT;
                    low_nib = '0;
                    r.ev = EV_OS_DONE;
                end
                r.sop = sop;
                r.crc = crc_reg;
                pending_events.push_back(r);
                return 0;
            end
            valid = 0;
            nib = '0;
            for (int n = 0; n < 16; n++)
            begin
                if (encode(4'(n)) == sym)
                begin
                    valid = 1;
                    nib = 4'(n);
                end
            end
            crc_reg = crc_step(crc_reg, nib);
            r.nib = nib;
            r.err = !valid;
            r.idx = (bytes_done > 63) ? 6'd63 : 6'(bytes_done);
            r.crc = crc_reg;
            r.sop = sop;
            if (sym_cnt == 4)
            begin
                low_nib = nib;
                sym_cnt = 5;
                r.ev = EV_LOW_NIB;
                pending_events.push_back(r);
                return 0;
            end
            r.ev = EV_BYTE;
            r.dbyte = {nib, low_nib};
            pending_events.push_back(r);
            sym_cnt = 4;
            if (bytes_done < 255)
                bytes_done++;
            if (bytes_done >= MAX_BYTES)
            begin
                sym_cnt = 0;
                return 1;
            end
            return 0;
        endfunction

        function void take_line_byte(logic [7:0] d);
            logic [15:0] win;
            int          s;
            bit          ended;
            rx_result_t  r;
            win = {d, prev_byte};
            if (sym_cnt == 0)
            begin
                for (s = 8; s >= 1; s--)
                    if (win[s +: 5] == K_SYNC1 || win[s +: 5] == K_RST1)
                        break;
                if (s == 0)
                begin
                    prev_byte = d;
                    return;
                end
                bit_off = s;
                sop = SOP_NONE;
                bytes_done = 0;
            end
            ended = take_symbol(win[bit_off +: 5]);
            bit_off = next_off(bit_off);
            if (!ended && bit_off < 4)
            begin
                ended = take_symbol(d[bit_off +: 5]);
                bit_off = next_off(bit_off);
            end
            prev_byte = d;
            r = pending_events.pop_back();
            r.last = 1'b1;
            pending_events.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(rx_result_t got);
            rx_result_t want;
            if (pending_events.size() == 0)
            begin
                $error("unexpected result: event_res %0d raw_symbol 0x%0h",
                       got.ev, got.sym);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            compare("event_res", want.ev, got.ev);
            compare("sop_type", want.sop, got.sop);
            compare("raw_symbol", want.sym, got.sym);
            compare("nibble", want.nib, got.nib);
            compare("data_byte", want.dbyte, got.dbyte);
            compare("byte_index", want.idx, got.idx);
            compare("code_error", want.err, got.err);
            compare("crc_value", want.crc, got.crc);
            compare("crc_ok", want.ok, got.ok);
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  line_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  event_res;
    logic [2:0]  sop_type;
    logic [4:0]  raw_symbol;
    logic [3:0]  nibble;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic        code_error;
    logic [31:0] crc_value;
    logic        crc_ok;
    logic        last;

    pd_rx_scoreboard board;
    logic [7:0]      stim_bytes[$];
    bit              line_bits[$];

    pd_4b5b_packet_receiver #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .line_byte  (line_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .sop_type   (sop_type),
        .raw_symbol (raw_symbol),
        .nibble     (nibble),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .code_error (code_error),
        .crc_value  (crc_value),
        .crc_ok     (crc_ok),
        .last       (last)
    );

    // Line bits go out earliest first; full bytes move to the stimulus list.
    function automatic void push_bits(logic [31:0] v, int count);
        for (int i = 0; i < count; i++)
            line_bits.push_back(v[i]);
        while (line_bits.size() >= 8)
        begin
            logic [7:0] b;
            for (int i = 0; i < 8; i++)
                b[i] = line_bits.pop_front();
            stim_bytes.push_back(b);
        end
    endfunction

    function automatic void pad_to_byte();
        if (line_bits.size() > 0)
            push_bits(32'h5555_5555, 8 - line_bits.size());
    endfunction

    // A pattern of 7 picks random K-codes or random symbols; eop_at of 1 to 3 cuts the ordered set.
    function automatic void add_packet(int pattern, bit damage_os, int eop_at, int n_data,
                                       bit bad_crc, int bad_code_pct, int pre_bits);
        logic [4:0]  os[4];
        logic [31:0] crc;
        logic [7:0]  payload[$];
        logic [4:0]  sym;
        for (int i = 0; i < pre_bits; i++)
            push_bits(32'((i + 1) % 2), 1);
        for (int i = 0; i < 4; i++)
        begin
            if (pattern < 7)
                os[i] = pd_rx_scoreboard::pattern_sym(pattern, i);
            else if ($urandom_range(0, 1) == 1)
                os[i] = pd_rx_scoreboard::pattern_sym($urandom_range(0, 6),
                                                      $urandom_range(0, 3));
            else
                os[i] = 5'($urandom);
        end
        if (damage_os)
            os[$urandom_range(0, 3)] = 5'($urandom);
        for (int i = 0; i < 4; i++)
        begin
            if (i == eop_at)
            begin
                push_bits(K_EOP, 5);
                return;
            end
            push_bits(os[i], 5);
        end
        crc = CRC_INIT;
        for (int i = 0; i < n_data; i++)
        begin
            payload.push_back(8'($urandom));
            crc = pd_rx_scoreboard::crc_step(crc, payload[i][3:0]);
            crc = pd_rx_scoreboard::crc_step(crc, payload[i][7:4]);
        end
        crc = ~crc;
        if (bad_crc)
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++)
            payload.push_back(crc[8 * i +: 8]);
        foreach (payload[i])
        begin
            for (int h = 0; h < 2; h++)
            begin
                sym = pd_rx_scoreboard::encode(payload[i][4 * h +: 4]);
                if ($urandom_range(0, 99) < bad_code_pct)
                    sym = 5'($urandom);
                push_bits(sym, 5);
            end
        end
        push_bits(K_EOP, 5);
        push_bits($urandom, $urandom_range(0, 12));
    endfunction

    task automatic send_line_bytes(int pause_at);
        int gap;
        bit quiet;
        quiet = 0;
        foreach (stim_bytes[i])
        begin
            if ($urandom_range(0, 39) == 0)
                quiet = !quiet;
            gap = quiet ? 0 : $urandom_range(0, 15);
            if (i == pause_at)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (board.pending_events.size() != 0)
                    @(posedge clk);
            end
            else if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            line_byte <= stim_bytes[i];
            do
                @(posedge clk);
            while (!in_ready);
            board.take_line_byte(stim_bytes[i]);
        end
        in_valid <= 1'b0;
    endtask

    task automatic take_results();
        int stall;
        bit quiet;
        quiet = 0;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                quiet = !quiet;
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            board.check_result(rx_result_t'{event_res, sop_type, raw_symbol, nibble, data_byte,
                                            byte_index, code_error, crc_value, crc_ok, last});
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int directed_end;
        int n_pkt;
        int kind;
        int eop_at;
        int n_data;
        rst_n = 1'b0;
        in_valid = 1'b0;
        line_byte = '0;
        out_ready = 1'b0;
        board = new();

        // All zeros, then all ones locks on a Sync-1, and the third byte puts an
        // EOP into the ordered set.
        push_bits(8'h00, 8);
        push_bits(8'hff, 8);
        push_bits(8'h06, 8);
        add_packet(0, 0, -1, 1, 0, 0, 8);
        add_packet(5, 0, -1, 1, 1, 50, 6);
        pad_to_byte();
        directed_end = stim_bytes.size();

        n_pkt = 0;
        while (stim_bytes.size() < directed_end + 510)
        begin
            kind = $urandom_range(0, 9);
            if (n_pkt == 3 || $urandom_range(0, 39) == 0)
                add_packet($urandom_range(0, 6), 0, -1, $urandom_range(64, 70), 0, 0,
                           $urandom_range(4, 24));
            else if (kind == 0)
                push_bits($urandom, $urandom_range(8, 32));
            else if (kind <= 2)
            begin
                eop_at = $urandom_range(0, 5);
                if (eop_at == 0 || eop_at > 3)
                    eop_at = -1;
                add_packet($urandom_range(0, 7), $urandom_range(0, 1), eop_at,
                           $urandom_range(0, 4), 1, 20, $urandom_range(0, 24));
            end
            else
            begin
                n_data = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 30)
                                                     : $urandom_range(0, 6);
                add_packet($urandom_range(0, 6), $urandom_range(0, 5) == 0, -1, n_data,
                           $urandom_range(0, 7) == 0,
                           ($urandom_range(0, 4) == 0) ? 3 : 0, $urandom_range(4, 40));
            end
            n_pkt++;
        end
        pad_to_byte();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        fork
            take_results();
        join_none
        send_line_bytes(directed_end);
        while (board.pending_events.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
